[rtl/mid_pkg.sv]
// ----------------------------------------------------------------------------
// mid_pkg
// Shared types, operation class codes and the branch-condition helper function of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mid_pkg;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned FLAGS_W = 4;
  localparam int unsigned CLASS_W = 6;
  localparam int unsigned OFFS_W  = 8;
  localparam int unsigned APB_AW  = 2;
  localparam int unsigned APB_DW  = 32;

  localparam logic [APB_AW-1:0] REG_FLOAT_EXT = 2'd0;
  localparam logic              FLOAT_EXT_RESET = 1'b1;

  localparam logic [CLASS_W-1:0] CLS_INVALID = 6'd0;
  localparam logic [CLASS_W-1:0] CLS_ADD     = 6'd6;
  localparam logic [CLASS_W-1:0] CLS_SUB     = 6'd7;
  localparam logic [CLASS_W-1:0] CLS_JSR     = 6'd8;
  localparam logic [CLASS_W-1:0] CLS_MUL     = 6'd9;
  localparam logic [CLASS_W-1:0] CLS_SOB     = 6'd14;
  localparam logic [CLASS_W-1:0] CLS_CLR     = 6'd15;
  localparam logic [CLASS_W-1:0] CLS_SXT     = 6'd27;
  localparam logic [CLASS_W-1:0] CLS_JMP     = 6'd28;
  localparam logic [CLASS_W-1:0] CLS_SWAB    = 6'd29;
  localparam logic [CLASS_W-1:0] CLS_MARK    = 6'd30;
  localparam logic [CLASS_W-1:0] CLS_MFPI    = 6'd31;
  localparam logic [CLASS_W-1:0] CLS_MTPI    = 6'd32;
  localparam logic [CLASS_W-1:0] CLS_RTS     = 6'd33;
  localparam logic [CLASS_W-1:0] CLS_BRANCH  = 6'd34;
  localparam logic [CLASS_W-1:0] CLS_TRAP    = 6'd35;
  localparam logic [CLASS_W-1:0] CLS_CC      = 6'd36;
  localparam logic [CLASS_W-1:0] CLS_HALT    = 6'd37;
  localparam logic [CLASS_W-1:0] CLS_WAIT    = 6'd38;
  localparam logic [CLASS_W-1:0] CLS_RTI     = 6'd39;
  localparam logic [CLASS_W-1:0] CLS_RESET   = 6'd40;
  localparam logic [CLASS_W-1:0] CLS_FLOAT   = 6'd41;

  localparam logic [CLASS_W-1:0] SOP_BIAS    = 6'd25;

  typedef struct packed {
    logic               grp_hit;
    logic [CLASS_W-1:0] grp_cls;
    logic               br_hit;
    logic               trap_hit;
    logic               cc_hit;
    logic               word_hit;
    logic [CLASS_W-1:0] word_cls;
    logic               float_hit;
  } predec_t;

  function automatic logic branch_cond(input logic [7:0] hb, input logic [FLAGS_W-1:0] f);
    logic n, z, v, c, res;
    n = f[3];
    z = f[2];
    v = f[1];
    c = f[0];
    unique case (hb)
      8'h01:   res = 1'b1;
      8'h02:   res = !z;
      8'h03:   res = z;
      8'h04:   res = !(n ^ v);
      8'h05:   res = n ^ v;
      8'h06:   res = !(n ^ v) && !z;
      8'h07:   res = (n ^ v) || z;
      8'h80:   res = !n;
      8'h81:   res = n;
      8'h82:   res = !c && !z;
      8'h83:   res = c || z;
      8'h84:   res = !v;
      8'h85:   res = v;
      8'h86:   res = !c;
      8'h87:   res = c;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/mid_if.sv]
// ----------------------------------------------------------------------------
// mid_in_if / mid_out_if
// Valid/ready channels carrying decoder input and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mid_in_if;
  logic                         valid;
  logic                         ready;
  logic [mid_pkg::WORD_W-1:0]   instruction_word;
  logic [mid_pkg::FLAGS_W-1:0]  cond_flags;

  modport source (output valid, output instruction_word, output cond_flags, input ready);
  modport sink   (input valid, input instruction_word, input cond_flags, output ready);
endinterface

interface mid_out_if;
  logic                          valid;
  logic                          ready;
  logic [mid_pkg::CLASS_W-1:0]   op_class;
  logic                          branch_taken;
  logic signed [mid_pkg::OFFS_W-1:0] branch_offset;
  logic                          flags_write;
  logic [mid_pkg::FLAGS_W-1:0]   new_flags;

  modport source (output valid, output op_class, output branch_taken, output branch_offset,
                  output flags_write, output new_flags, input ready);
  modport sink   (input valid, input op_class, input branch_taken, input branch_offset,
                  input flags_write, input new_flags, output ready);
endinterface

`default_nettype wire

[rtl/minicomputer_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// minicomputer_instruction_decoder
// Three-stage decode of a 16-bit instruction word into operation class,
// branch decision and condition-code update.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Contents
//  in_ch     in         valid/ready         instruction_word, cond_flags
//  out_ch    out        valid/ready         op_class, branch_taken, branch_offset,
//                                           flags_write, new_flags
//  APB       in         psel/penable/pready float_ext_enable at address 0
//
// One item per cycle while the output is not stalled; an accepted item passes the
// input register, the group match register and the output register (priority and
// flag logic), and its result item is offered from the output register.
// Reset clears all stage valid bits and sets float_ext_enable to 1.
// A stalled output holds its item, and each stage loads only when it is empty
// or its successor moves, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module minicomputer_instruction_decoder #(
  parameter int unsigned APB_AW = mid_pkg::APB_AW
) (
  input  wire logic              clk,
  input  wire logic              rst,
  mid_in_if.sink                 in_ch,
  mid_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [mid_pkg::APB_DW-1:0] pwdata,
  output logic [mid_pkg::APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic float_ext_enable;

  logic                         v0, v1, v2;
  logic                         en0, en1, en2;
  logic [mid_pkg::WORD_W-1:0]   word0, word1;
  logic [mid_pkg::FLAGS_W-1:0]  flags0, flags1;
  mid_pkg::predec_t             pd_comb, pd1;

  logic [mid_pkg::CLASS_W-1:0]  cls_next;
  logic                         taken_next;
  logic [mid_pkg::OFFS_W-1:0]   offs_next;
  logic                         fw_next;
  logic [mid_pkg::FLAGS_W-1:0]  nf_next;

  assign pready = 1'b1;
  assign prdata = {{(mid_pkg::APB_DW-1){1'b0}}, float_ext_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      float_ext_enable <= mid_pkg::FLOAT_EXT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == APB_AW'(mid_pkg::REG_FLOAT_EXT)) begin
      float_ext_enable <= pwdata[0];
    end
  end

  assign en2 = !v2 || out_ch.ready;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign in_ch.ready = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) v0 <= in_ch.valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      word0  <= in_ch.instruction_word;
      flags0 <= in_ch.cond_flags;
    end
  end

  mid_predecode u_predecode (
    .word             (word0),
    .float_ext_enable (float_ext_enable),
    .pd               (pd_comb)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      word1  <= word0;
      flags1 <= flags0;
      pd1    <= pd_comb;
    end
  end

  always_comb begin
    taken_next = 1'b0;
    offs_next  = '0;
    fw_next    = 1'b0;
    nf_next    = flags1;
    priority if (pd1.grp_hit) begin
      cls_next = pd1.grp_cls;
    end else if (pd1.br_hit) begin
      cls_next   = mid_pkg::CLS_BRANCH;
      taken_next = mid_pkg::branch_cond(word1[15:8], flags1);
      offs_next  = word1[7:0];
    end else if (pd1.trap_hit) begin
      cls_next = mid_pkg::CLS_TRAP;
    end else if (pd1.cc_hit) begin
      cls_next = mid_pkg::CLS_CC;
      fw_next  = 1'b1;
      nf_next  = word1[4] ? (flags1 | word1[3:0]) : (flags1 & ~word1[3:0]);
    end else if (pd1.word_hit) begin
      cls_next = pd1.word_cls;
    end else if (pd1.float_hit) begin
      cls_next = mid_pkg::CLS_FLOAT;
    end else begin
      cls_next = mid_pkg::CLS_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      out_ch.op_class      <= cls_next;
      out_ch.branch_taken  <= taken_next;
      out_ch.branch_offset <= offs_next;
      out_ch.flags_write   <= fw_next;
      out_ch.new_flags     <= nf_next;
    end
  end

  assign out_ch.valid = v2;

endmodule

`default_nettype wire

[rtl/mid_predecode.sv]
// ----------------------------------------------------------------------------
// mid_predecode
// Matches an instruction word against every opcode group in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module mid_predecode (
  input  wire logic [mid_pkg::WORD_W-1:0] word,
  input  wire logic                       float_ext_enable,
  output mid_pkg::predec_t                pd
);

  logic [2:0] top3;
  logic [3:0] top4;
  logic [6:0] g9;
  logic [8:0] g6;
  logic [9:0] m6;
  logic [7:0] hb;

  assign top3 = word[14:12];
  assign top4 = word[15:12];
  assign g9   = word[15:9];
  assign g6   = word[14:6];
  assign m6   = word[15:6];
  assign hb   = word[15:8];

  always_comb begin
    pd = '0;
    priority if (top3 >= 3'd1 && top3 <= 3'd5) begin
      pd.grp_hit = 1'b1;
      pd.grp_cls = {3'b000, top3};
    end else if (top4 == 4'o06) begin
      pd.grp_hit = 1'b1;
      pd.grp_cls = mid_pkg::CLS_ADD;
    end else if (top4 == 4'o16) begin
      pd.grp_hit = 1'b1;
      pd.grp_cls = mid_pkg::CLS_SUB;
    end else if (g9 == 7'o004) begin
      pd.grp_hit = 1'b1;
      pd.grp_cls = mid_pkg::CLS_JSR;
    end else if (g9 >= 7'o070 && g9 <= 7'o074) begin
      pd.grp_hit = 1'b1;
      pd.grp_cls = mid_pkg::CLS_MUL + {3'b000, g9[2:0]};
    end else if (g9 == 7'o077) begin
      pd.grp_hit = 1'b1;
      pd.grp_cls = mid_pkg::CLS_SOB;
    end else if (g6 >= 9'o050 && g6 <= 9'o063) begin
      pd.grp_hit = 1'b1;
      pd.grp_cls = g6[5:0] - mid_pkg::SOP_BIAS;
    end else if (g6 == 9'o067) begin
      pd.grp_hit = 1'b1;
      pd.grp_cls = mid_pkg::CLS_SXT;
    end else if (m6 == 10'o0001) begin
      pd.grp_hit = 1'b1;
      pd.grp_cls = mid_pkg::CLS_JMP;
    end else if (m6 == 10'o0003) begin
      pd.grp_hit = 1'b1;
      pd.grp_cls = mid_pkg::CLS_SWAB;
    end else if (m6 == 10'o0064) begin
      pd.grp_hit = 1'b1;
      pd.grp_cls = mid_pkg::CLS_MARK;
    end else if (m6 == 10'o0065) begin
      pd.grp_hit = 1'b1;
      pd.grp_cls = mid_pkg::CLS_MFPI;
    end else if (m6 == 10'o0066) begin
      pd.grp_hit = 1'b1;
      pd.grp_cls = mid_pkg::CLS_MTPI;
    end else if (word[15:3] == 13'o00020) begin
      pd.grp_hit = 1'b1;
      pd.grp_cls = mid_pkg::CLS_RTS;
    end else begin
      pd.grp_hit = 1'b0;
    end

    pd.br_hit   = (hb >= 8'h01 && hb <= 8'h07) || (hb >= 8'h80 && hb <= 8'h87);
    pd.trap_hit = (g9 == 7'o104) || (word == 16'd3) || (word == 16'd4);
    pd.cc_hit   = (word[15:5] == 11'o0005);

    pd.word_hit = 1'b1;
    unique case (word)
      16'd0:   pd.word_cls = mid_pkg::CLS_HALT;
      16'd1:   pd.word_cls = mid_pkg::CLS_WAIT;
      16'd2:   pd.word_cls = mid_pkg::CLS_RTI;
      16'd5:   pd.word_cls = mid_pkg::CLS_RESET;
      16'd6:   pd.word_cls = mid_pkg::CLS_RTI;
      default: begin
        pd.word_hit = 1'b0;
        pd.word_cls = mid_pkg::CLS_INVALID;
      end
    endcase

    pd.float_hit = float_ext_enable &&
                   (word == 16'o170001 || word == 16'o170002 ||
                    word == 16'o170011 || word == 16'o170012);
  end

endmodule

`default_nettype wire

[rtl/mid_checker.sv]
// ----------------------------------------------------------------------------
// mid_checker
// Port-level checks of the decoder's result items, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mid_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [mid_pkg::CLASS_W-1:0]    op_class,
  input wire logic                           branch_taken,
  input wire logic [mid_pkg::OFFS_W-1:0]     branch_offset,
  input wire logic                           flags_write
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(op_class))
    else $error("result item changed while stalled");

  a_fw_cc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (flags_write == (op_class == mid_pkg::CLS_CC)))
    else $error("flags_write does not match condition-code class");

  a_taken_branch: assert property (@(posedge clk) disable iff (rst)
    out_valid && branch_taken |-> op_class == mid_pkg::CLS_BRANCH)
    else $error("branch taken on a non-branch item");

  a_offs_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && op_class != mid_pkg::CLS_BRANCH |-> branch_offset == '0)
    else $error("nonzero offset on a non-branch item");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind minicomputer_instruction_decoder mid_checker u_mid_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .op_class      (out_ch.op_class),
  .branch_taken  (out_ch.branch_taken),
  .branch_offset (out_ch.branch_offset),
  .flags_write   (out_ch.flags_write)
);

`default_nettype wire
